FILE: rtl/bis_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and lerp functions for the bilinear image scaler.
package bis_pkg;

	localparam int PIX_W       = 32;
	localparam int CHAN_W      = 8;
	localparam int NUM_CHAN    = PIX_W / CHAN_W;
	localparam int WGT_W       = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int SIZE_REG_W  = 9;
	localparam int NUM_BANKS   = 4;
	localparam int BANK_W      = 2;

	localparam logic [CFG_DATA_W-1:0] INV_SCALE_RST = 32'h0001_0000;
	localparam logic [WGT_W-1:0]      WGT_ONE       = 9'd256;
	localparam logic [16:0]           WGT_ROUND     = 17'd128;

	// Result FIFO and the credit count that keeps it from overflowing
	localparam int OUT_FIFO_DEPTH = 8;
	localparam int OUT_PTR_W      = $clog2(OUT_FIFO_DEPTH);
	localparam int CREDIT_W       = $clog2(OUT_FIFO_DEPTH + 1);

	typedef enum logic [0:0] {
		ACT_WRITE  = 1'b0,
		ACT_RENDER = 1'b1
	} act_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SRC_WIDTH  = 2'd0,
		CFG_SRC_HEIGHT = 2'd1,
		CFG_INV_SCALE  = 2'd2
	} cfg_idx_e;

	// Neighbor selection carried from the address stage to the interpolator
	typedef struct packed {
		logic x_odd;
		logic y_odd;
		logic x_clamp;
		logic y_clamp;
	} rd_sel_t;

	function automatic logic [CHAN_W-1:0] lerp_chan(
		input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b,
		input logic [WGT_W-1:0]  w
	);
		logic [16:0] sum;
		sum = 17'(a) * 17'(WGT_ONE - w) + 17'(b) * 17'(w);
		return sum[15:8];
	endfunction

	function automatic logic [PIX_W-1:0] lerp_pixel(
		input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b,
		input logic [WGT_W-1:0] w
	);
		logic [PIX_W-1:0] res;
		for (int c = 0; c < NUM_CHAN; c++) begin
			res[c*CHAN_W +: CHAN_W] = lerp_chan(a[c*CHAN_W +: CHAN_W],
				b[c*CHAN_W +: CHAN_W], w);
		end
		return res;
	endfunction

endpackage

FILE: rtl/bis_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for scaler requests and rendered pixels.
interface bis_in_if;
	logic        valid;
	logic        ready;
	logic [0:0]  action;
	logic [7:0]  src_x;
	logic [7:0]  src_y;
	logic [31:0] src_pixel;
	logic [15:0] dst_x;
	logic [15:0] dst_y;

	modport source (output valid, action, src_x, src_y, src_pixel, dst_x, dst_y,
		input ready);
	modport sink (input valid, action, src_x, src_y, src_pixel, dst_x, dst_y,
		output ready);
endinterface

interface bis_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_pixel;

	modport source (output valid, out_pixel, input ready);
	modport sink (input valid, out_pixel, output ready);
endinterface

FILE: rtl/uniform_bilinear_image_scaler.sv
`timescale 1ns / 1ps
// Top level: config registers, coordinate mapping, banked frame store and output FIFO.
//
//   channel   dir  handshake              payload
//   pix_in    in   valid / ready          action, src_x, src_y, src_pixel, dst_x, dst_y
//   pix_out   out  valid / ready          out_pixel
//   cfg       in   cfg_we (no stall)      cfg_index, cfg_wdata
//
// One item per cycle while credits remain. A render's result reaches pix_out through these
// steps: multiply at acceptance, frame store read of all four neighbors from the parity
// banks, horizontal lerp, vertical lerp into the result FIFO. Writes pass through the stage 1
// register into the store, in order with renders. Reset clears control only; the store is
// not cleared. pix_in stalls only when 8 renders are accepted but not yet taken.
module uniform_bilinear_image_scaler #(
	parameter int MAX_SRC_WIDTH  = 256,
	parameter int MAX_SRC_HEIGHT = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bis_in_if.sink                         pix_in,
	bis_out_if.source                      pix_out,
	input  logic                           cfg_we,
	input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int XW  = $clog2(MAX_SRC_WIDTH);
	localparam int YW  = $clog2(MAX_SRC_HEIGHT);
	localparam int XHW = (XW > 1) ? XW - 1 : 1;
	localparam int YHW = (YW > 1) ? YW - 1 : 1;
	localparam int AW  = XHW + YHW;

	// Configuration: keep the last valid index per axis
	logic [XW-1:0]                   last_x_q, new_last_x;
	logic [YW-1:0]                   last_y_q, new_last_y;
	logic [bis_pkg::CFG_DATA_W-1:0]  inv_scale_q;
	logic [bis_pkg::SIZE_REG_W-1:0]  cfg_size;

	always_comb begin
		cfg_size = cfg_wdata[bis_pkg::SIZE_REG_W-1:0];
		if (cfg_size == '0) begin
			new_last_x = '0;
		end else if (32'(cfg_size) > MAX_SRC_WIDTH) begin
			new_last_x = XW'(MAX_SRC_WIDTH - 1);
		end else begin
			new_last_x = XW'(cfg_size - 1'b1);
		end
		if (cfg_size == '0) begin
			new_last_y = '0;
		end else if (32'(cfg_size) > MAX_SRC_HEIGHT) begin
			new_last_y = YW'(MAX_SRC_HEIGHT - 1);
		end else begin
			new_last_y = YW'(cfg_size - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q    <= '0;
			last_y_q    <= '0;
			inv_scale_q <= bis_pkg::INV_SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bis_pkg::CFG_SRC_WIDTH:  last_x_q    <= new_last_x;
				bis_pkg::CFG_SRC_HEIGHT: last_y_q    <= new_last_y;
				bis_pkg::CFG_INV_SCALE:  inv_scale_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input acceptance with credits for the result FIFO
	logic                          accept, render_acc, out_pop;
	logic [bis_pkg::CREDIT_W-1:0]  credit_q;

	assign pix_in.ready = credit_q != bis_pkg::CREDIT_W'(bis_pkg::OUT_FIFO_DEPTH);
	assign accept       = pix_in.valid && pix_in.ready;
	assign render_acc   = accept && pix_in.action == bis_pkg::ACT_RENDER;
	assign out_pop      = pix_out.valid && pix_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + bis_pkg::CREDIT_W'(render_acc)
				- bis_pkg::CREDIT_W'(out_pop);
		end
	end

	// Stage 1: source coordinates in 16.16, modulo 2^32
	logic                           valid_s1;
	bis_pkg::act_e                  act_s1;
	logic [31:0]                    prod_x_s1, prod_y_s1;
	logic [7:0]                     wr_x_s1, wr_y_s1;
	logic [bis_pkg::PIX_W-1:0]      wr_data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1     <= bis_pkg::act_e'(pix_in.action);
			prod_x_s1  <= 32'(pix_in.dst_x) * inv_scale_q;
			prod_y_s1  <= 32'(pix_in.dst_y) * inv_scale_q;
			wr_x_s1    <= pix_in.src_x;
			wr_y_s1    <= pix_in.src_y;
			wr_data_s1 <= pix_in.src_pixel;
		end
	end

	// Clamp, weights and bank addresses
	logic                        clamp_x, clamp_y;
	logic [XW-1:0]               x0;
	logic [YW-1:0]               y0;
	logic [15:0]                 frac_x, frac_y;
	logic [bis_pkg::WGT_W-1:0]   wx, wy;
	logic [XHW-1:0]              xh_odd, xh_even;
	logic [YHW-1:0]              yh_odd, yh_even;
	logic [AW-1:0]               rd_addr [bis_pkg::NUM_BANKS];
	logic                        rd_en, wr_en;
	logic [bis_pkg::BANK_W-1:0]  wr_bank;
	logic [AW-1:0]               wr_addr;

	always_comb begin
		clamp_x = prod_x_s1[31:16] >= 16'(last_x_q);
		clamp_y = prod_y_s1[31:16] >= 16'(last_y_q);
		x0      = clamp_x ? last_x_q : prod_x_s1[16 +: XW];
		y0      = clamp_y ? last_y_q : prod_y_s1[16 +: YW];
		frac_x  = clamp_x ? 16'd0 : prod_x_s1[15:0];
		frac_y  = clamp_y ? 16'd0 : prod_y_s1[15:0];
		wx      = bis_pkg::WGT_W'((17'(frac_x) + bis_pkg::WGT_ROUND) >> 8);
		wy      = bis_pkg::WGT_W'((17'(frac_y) + bis_pkg::WGT_ROUND) >> 8);
		// The odd neighbor is always at x0/2; the even one moves up when x0 is odd
		xh_odd  = XHW'(x0 >> 1);
		xh_even = xh_odd + XHW'(x0[0]);
		yh_odd  = YHW'(y0 >> 1);
		yh_even = yh_odd + YHW'(y0[0]);
		for (int b = 0; b < bis_pkg::NUM_BANKS; b++) begin
			rd_addr[b] = {(b >= 2) ? yh_odd : yh_even, (b % 2 == 1) ? xh_odd : xh_even};
		end
		rd_en   = valid_s1 && act_s1 == bis_pkg::ACT_RENDER;
		// Drop writes that fall outside the store
		wr_en   = valid_s1 && act_s1 == bis_pkg::ACT_WRITE
			&& 32'(wr_x_s1) < MAX_SRC_WIDTH && 32'(wr_y_s1) < MAX_SRC_HEIGHT;
		wr_bank = {wr_y_s1[0], wr_x_s1[0]};
		wr_addr = {YHW'(wr_y_s1 >> 1), XHW'(wr_x_s1 >> 1)};
	end

	// Stage 2: neighbor data out of the store
	logic                       valid_s2;
	bis_pkg::rd_sel_t           sel_s2;
	logic [bis_pkg::WGT_W-1:0]  wx_s2, wy_s2;
	logic [bis_pkg::PIX_W-1:0]  bank_data [bis_pkg::NUM_BANKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		sel_s2.x_odd   <= x0[0];
		sel_s2.y_odd   <= y0[0];
		sel_s2.x_clamp <= clamp_x;
		sel_s2.y_clamp <= clamp_y;
		wx_s2          <= wx;
		wy_s2          <= wy;
	end

	bis_frame_store #(
		.AW (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_bank (wr_bank),
		.wr_addr (wr_addr),
		.wr_data (wr_data_s1),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (bank_data)
	);

	logic                      push_valid;
	logic [bis_pkg::PIX_W-1:0] push_pixel;

	bis_interp u_interp (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s2   (valid_s2),
		.sel_s2     (sel_s2),
		.wx_s2      (wx_s2),
		.wy_s2      (wy_s2),
		.bank_data  (bank_data),
		.push_valid (push_valid),
		.push_pixel (push_pixel)
	);

	bis_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_data (push_pixel),
		.pix_out   (pix_out)
	);

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= bis_pkg::CREDIT_W'(bis_pkg::OUT_FIFO_DEPTH))
		else $error("credit count above FIFO depth");

	a_render_result: assert property (@(posedge clk) disable iff (!arst_n)
		render_acc |-> ##3 push_valid)
		else $error("accepted render produced no result");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!render_acc |-> ##3 !push_valid)
		else $error("result produced without an accepted render");

	a_out_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid |-> credit_q != '0)
		else $error("result shown with no render outstanding");

endmodule

FILE: rtl/bis_frame_store.sv
`timescale 1ns / 1ps
// Frame store split into four parity banks, one write and one read per bank a cycle.
module bis_frame_store #(
	parameter int AW = 14
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [bis_pkg::BANK_W-1:0]    wr_bank,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [bis_pkg::PIX_W-1:0]     wr_data,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr [bis_pkg::NUM_BANKS],
	output logic [bis_pkg::PIX_W-1:0]     rd_data [bis_pkg::NUM_BANKS]
);

	for (genvar b = 0; b < bis_pkg::NUM_BANKS; b++) begin : g_bank
		logic [bis_pkg::PIX_W-1:0] mem [2**AW];
		logic [bis_pkg::PIX_W-1:0] rd_q;

		always_ff @(posedge clk) begin
			if (wr_en && wr_bank == bis_pkg::BANK_W'(b)) begin
				mem[wr_addr] <= wr_data;
			end
			if (rd_en) begin
				rd_q <= mem[rd_addr[b]];
			end
		end

		assign rd_data[b] = rd_q;
	end

endmodule

FILE: rtl/bis_interp.sv
`timescale 1ns / 1ps
// Neighbor selection and two-pass packed lerp: horizontal registered, vertical to the FIFO.
module bis_interp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s2,
	input  bis_pkg::rd_sel_t              sel_s2,
	input  logic [bis_pkg::WGT_W-1:0]     wx_s2,
	input  logic [bis_pkg::WGT_W-1:0]     wy_s2,
	input  logic [bis_pkg::PIX_W-1:0]     bank_data [bis_pkg::NUM_BANKS],
	output logic                          push_valid,
	output logic [bis_pkg::PIX_W-1:0]     push_pixel
);

	logic [bis_pkg::PIX_W-1:0] a_top, b_top, a_bot, b_bot;
	logic                      valid_s3;
	logic [bis_pkg::PIX_W-1:0] top_s3, bot_s3;
	logic [bis_pkg::WGT_W-1:0] wy_s3;

	always_comb begin
		a_top = bank_data[{sel_s2.y_odd, sel_s2.x_odd}];
		b_top = bank_data[{sel_s2.y_odd, ~sel_s2.x_odd}];
		a_bot = bank_data[{~sel_s2.y_odd, sel_s2.x_odd}];
		b_bot = bank_data[{~sel_s2.y_odd, ~sel_s2.x_odd}];
		// At the last column or row the neighbor is the pixel itself
		if (sel_s2.x_clamp) begin
			b_top = a_top;
			b_bot = a_bot;
		end
		if (sel_s2.y_clamp) begin
			a_bot = a_top;
			b_bot = b_top;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		top_s3 <= bis_pkg::lerp_pixel(a_top, b_top, wx_s2);
		bot_s3 <= bis_pkg::lerp_pixel(a_bot, b_bot, wx_s2);
		wy_s3  <= wy_s2;
	end

	assign push_valid = valid_s3;
	assign push_pixel = bis_pkg::lerp_pixel(top_s3, bot_s3, wy_s3);

endmodule

FILE: rtl/bis_out_fifo.sv
`timescale 1ns / 1ps
// Result FIFO that decouples the pipeline from output backpressure.
module bis_out_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic [bis_pkg::PIX_W-1:0] push_data,
	bis_out_if.source                 pix_out
);

	logic [bis_pkg::PIX_W-1:0]   mem_q [bis_pkg::OUT_FIFO_DEPTH];
	logic [bis_pkg::OUT_PTR_W:0] wr_ptr_q, rd_ptr_q;
	logic                        full, pop;

	assign full = (wr_ptr_q[bis_pkg::OUT_PTR_W] != rd_ptr_q[bis_pkg::OUT_PTR_W])
		&& (wr_ptr_q[bis_pkg::OUT_PTR_W-1:0] == rd_ptr_q[bis_pkg::OUT_PTR_W-1:0]);
	assign pix_out.valid     = wr_ptr_q != rd_ptr_q;
	assign pix_out.out_pixel = mem_q[rd_ptr_q[bis_pkg::OUT_PTR_W-1:0]];
	assign pop               = pix_out.valid && pix_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q[bis_pkg::OUT_PTR_W-1:0]] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("result pushed into a full FIFO");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(!pix_out.valid && !push) |=> !pix_out.valid)
		else $error("FIFO shows a result that was never pushed");

endmodule

FILE: dv/uniform_bilinear_image_scaler_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench: frame store writes and bilinear renders checked against a predictor.
module uniform_bilinear_image_scaler_tb;

	localparam int STORE_DIM = 256;
	localparam logic [31:0] LANE_MASK = 32'h00FF_00FF;
	localparam logic [bis_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
	localparam int SRC_SIDE = 0;
	localparam int SNK_SIDE = 1;

	typedef struct packed {
		bis_pkg::act_e action;
		logic [7:0]    src_x;
		logic [7:0]    src_y;
		logic [31:0]   src_pixel;
		logic [15:0]   dst_x;
		logic [15:0]   dst_y;
	} scaler_req_t;

	class pixel_scoreboard;
		logic [31:0] store [STORE_DIM][STORE_DIM];
		bit          written [STORE_DIM][STORE_DIM];
		logic [8:0]  width_reg;
		logic [8:0]  height_reg;
		logic [31:0] scale_reg;
		logic [31:0] expected_pixels [$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned writes;
		int unsigned renders;

		function new();
			width_reg = 9'd1;
			height_reg = 9'd1;
			scale_reg = bis_pkg::INV_SCALE_RST;
		endfunction

		function void set_reg(logic [bis_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				bis_pkg::CFG_SRC_WIDTH: width_reg = data[8:0];
				bis_pkg::CFG_SRC_HEIGHT: height_reg = data[8:0];
				bis_pkg::CFG_INV_SCALE: scale_reg = data;
				default: ;
			endcase
		endfunction

		function int unsigned eff_size(logic [8:0] r);
			if (r == 9'd0) return 1;
			if (r > 9'(STORE_DIM)) return STORE_DIM;
			return 32'(r);
		endfunction

		function void map_coord(input logic [15:0] d, input int unsigned size,
			output int unsigned i0, output int unsigned i1, output logic [8:0] w);
			logic [63:0] prod;
			logic [31:0] s;
			logic [16:0] frac;
			int unsigned last;
			int unsigned idx;
			prod = 64'(d) * 64'(scale_reg);
			s = prod[31:0];
			last = size - 1;
			idx = 32'(s[31:16]);
			frac = 17'(s[15:0]);
			// clamp at the far edge and drop the fraction there
			if (idx >= last) begin
				idx = last;
				frac = '0;
			end
			i0 = idx;
			i1 = (idx < last) ? idx + 1 : last;
			w = 9'((frac + 17'd128) >> 8);
		endfunction

		// Four channels per 32-bit word, blended two at a time in 16-bit lanes
		function logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [8:0] w);
			logic [31:0] wa;
			logic [31:0] wb;
			logic [31:0] even;
			logic [31:0] odd;
			wa = 32'(bis_pkg::WGT_ONE - w);
			wb = 32'(w);
			even = (((a & LANE_MASK) * wa + (b & LANE_MASK) * wb) >> 8) & LANE_MASK;
			odd = ((((a >> 8) & LANE_MASK) * wa + ((b >> 8) & LANE_MASK) * wb) >> 8)
				& LANE_MASK;
			return even | (odd << 8);
		endfunction

		function logic [31:0] interpolate(logic [15:0] dx, logic [15:0] dy);
			int unsigned x0, x1, y0, y1;
			logic [8:0] wx, wy;
			logic [31:0] top, bot;
			map_coord(dx, eff_size(width_reg), x0, x1, wx);
			map_coord(dy, eff_size(height_reg), y0, y1, wy);
			top = blend(store[y0][x0], store[y0][x1], wx);
			bot = blend(store[y1][x0], store[y1][x1], wx);
			return blend(top, bot, wy);
		endfunction

		function void note_request(scaler_req_t r);
			if (r.action == bis_pkg::ACT_WRITE) begin
				store[r.src_y][r.src_x] = r.src_pixel;
				written[r.src_y][r.src_x] = 1'b1;
				writes++;
			end else begin
				expected_pixels.push_back(interpolate(r.dst_x, r.dst_y));
				renders++;
			end
		endfunction

		function void check_pixel(logic [31:0] got);
			logic [31:0] want;
			checked++;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("MISMATCH at %0t: pixel %h with no render outstanding", $realtime, got);
				return;
			end
			want = expected_pixels.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("MISMATCH at %0t: out_pixel expected %h got %h", $realtime, want, got);
			end
		endfunction

		function int unsigned pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bis_pkg::CFG_DATA_W-1:0] cfg_wdata;

	bis_in_if  req_bus();
	bis_out_if pix_bus();

	pixel_scoreboard sb;
	int unsigned     calm_left [2];
	int unsigned     settings_run;

	uniform_bilinear_image_scaler #(
		.MAX_SRC_WIDTH(STORE_DIM),
		.MAX_SRC_HEIGHT(STORE_DIM)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pix_in(req_bus),
		.pix_out(pix_bus),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("Timeout: %0d renders still outstanding", sb.pending());
		$display("uniform_bilinear_image_scaler verification failed");
		$finish;
	end

	// Mostly random gaps, with occasional runs of back-to-back transactions
	function automatic int unsigned next_gap(input int side);
		if (calm_left[side] != 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left[side] = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 8);
	endfunction

	function automatic scaler_req_t write_req(logic [7:0] x, logic [7:0] y, logic [31:0] pix);
		scaler_req_t r;
		r.action = bis_pkg::ACT_WRITE;
		r.src_x = x;
		r.src_y = y;
		r.src_pixel = pix;
		r.dst_x = 16'($urandom());
		r.dst_y = 16'($urandom());
		return r;
	endfunction

	function automatic scaler_req_t render_req(logic [15:0] dx, logic [15:0] dy);
		scaler_req_t r;
		r.action = bis_pkg::ACT_RENDER;
		r.src_x = 8'($urandom());
		r.src_y = 8'($urandom());
		r.src_pixel = $urandom();
		r.dst_x = dx;
		r.dst_y = dy;
		return r;
	endfunction

	// Largest destination coordinate that still lands inside the image, plus one
	function automatic int unsigned reach(int unsigned size);
		logic [63:0] q;
		if (sb.scale_reg == 32'd0) return 65535;
		q = (64'(size) << 16) / 64'(sb.scale_reg) + 64'd1;
		return (q > 64'd65535) ? 65535 : q[31:0];
	endfunction

	task automatic send(input scaler_req_t r);
		int unsigned gap;
		gap = next_gap(SRC_SIDE);
		repeat (gap) begin
			@(negedge clk);
			req_bus.valid = 1'b0;
		end
		@(negedge clk);
		req_bus.valid = 1'b1;
		req_bus.action = r.action;
		req_bus.src_x = r.src_x;
		req_bus.src_y = r.src_y;
		req_bus.src_pixel = r.src_pixel;
		req_bus.dst_x = r.dst_x;
		req_bus.dst_y = r.dst_y;
		do @(posedge clk); while (!req_bus.ready);
		sb.note_request(r);
	endtask

	// Hold the sender until every render has come back and trailing writes have landed
	task automatic settle();
		@(negedge clk);
		req_bus.valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [bis_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		sb.set_reg(idx, data);
	endtask

	task automatic program_regs(input logic [8:0] w, input logic [8:0] h,
		input logic [31:0] scale);
		settle();
		// upper bits of the size words are junk and must be dropped
		cfg_write(bis_pkg::CFG_SRC_WIDTH, ($urandom() & ~32'h1FF) | 32'(w));
		cfg_write(bis_pkg::CFG_SRC_HEIGHT, ($urandom() & ~32'h1FF) | 32'(h));
		cfg_write(bis_pkg::CFG_INV_SCALE, scale);
		cfg_write(CFG_UNUSED_IDX, $urandom());
		@(negedge clk);
		cfg_we = 1'b0;
		settings_run++;
	endtask

	// Define every source pixel in the active image, then probe the corners and a point near the origin
	task automatic fill_and_probe();
		int unsigned ew, eh;
		ew = sb.eff_size(sb.width_reg);
		eh = sb.eff_size(sb.height_reg);
		for (int y = 0; y < eh; y++)
			for (int x = 0; x < ew; x++)
				if (!sb.written[y][x]) send(write_req(8'(x), 8'(y), $urandom()));
		send(render_req(16'd0, 16'd0));
		send(render_req(16'hFFFF, 16'hFFFF));
		send(render_req(16'd1, 16'd1));
		send(render_req(16'd0, 16'hFFFF));
	endtask

	task automatic random_mix(input int unsigned count);
		int unsigned ew, eh, pick;
		ew = sb.eff_size(sb.width_reg);
		eh = sb.eff_size(sb.height_reg);
		for (int unsigned k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 15)
				send(write_req(8'($urandom_range(0, ew - 1)), 8'($urandom_range(0, eh - 1)),
					$urandom()));
			else if (pick < 30)
				send(write_req(8'($urandom()), 8'($urandom()), $urandom()));
			else if (pick < 80)
				send(render_req(16'($urandom_range(0, reach(ew))),
					16'($urandom_range(0, reach(eh)))));
			else
				send(render_req(16'($urandom()), 16'($urandom())));
		end
	endtask

	initial begin : pixel_sink
		int unsigned gap;
		pix_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = next_gap(SNK_SIDE);
			repeat (gap) begin
				@(negedge clk);
				pix_bus.ready = 1'b0;
			end
			@(negedge clk);
			pix_bus.ready = 1'b1;
			do @(posedge clk); while (!pix_bus.valid);
			sb.check_pixel(pix_bus.out_pixel);
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req_bus.valid = 1'b0;
		req_bus.action = bis_pkg::ACT_WRITE;
		req_bus.src_x = '0;
		req_bus.src_y = '0;
		req_bus.src_pixel = '0;
		req_bus.dst_x = '0;
		req_bus.dst_y = '0;
		sb = new();
		settings_run = 1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: one source pixel at unity scale
		send(write_req(8'd0, 8'd0, 32'hFFFF_FFFF));
		send(render_req(16'd0, 16'd0));
		send(render_req(16'hFFFF, 16'hFFFF));
		send(write_req(8'd0, 8'd0, 32'h0000_0000));
		send(render_req(16'h8000, 16'd1));
		send(write_req(8'hFF, 8'hFF, 32'hA5A5_5A5A));

		// 2x2 source with extreme channel values, half-pixel steps
		program_regs(9'd2, 9'd2, 32'h0000_8000);
		send(write_req(8'd0, 8'd0, 32'h0000_0000));
		send(write_req(8'd1, 8'd0, 32'hFFFF_FFFF));
		send(write_req(8'd0, 8'd1, 32'h00FF_00FF));
		send(write_req(8'd1, 8'd1, 32'hFF00_FF00));
		fill_and_probe();
		send(render_req(16'd1, 16'd0));
		send(render_req(16'd0, 16'd1));
		send(render_req(16'd3, 16'd3));
		random_mix(50);

		program_regs(9'd0, 9'd0, bis_pkg::INV_SCALE_RST);
		fill_and_probe();
		random_mix(30);

		program_regs(9'd8, 9'd6, 32'h0000_4000);
		fill_and_probe();
		random_mix(50);

		program_regs(9'd256, 9'd1, 32'h0000_C000);
		fill_and_probe();
		random_mix(50);

		program_regs(9'd511, 9'd1, 32'hFFFF_FFFF);
		fill_and_probe();
		random_mix(50);

		program_regs(9'd1, 9'd511, 32'h0001_0000);
		fill_and_probe();
		random_mix(50);

		program_regs(9'd3, 9'd5, 32'h0002_8000);
		fill_and_probe();
		random_mix(50);

		program_regs(9'd6, 9'd6, 32'h0000_0000);
		fill_and_probe();
		random_mix(30);

		program_regs(9'd6, 9'd6, 32'h0000_0001);
		fill_and_probe();
		random_mix(30);

		// fraction just under one rounds to a full weight
		program_regs(9'd10, 9'd8, 32'h0000_FFC0);
		fill_and_probe();
		random_mix(50);

		program_regs(9'd12, 9'd9, $urandom());
		fill_and_probe();
		random_mix(50);

		for (int k = 0; k < 4; k++) begin
			program_regs(9'($urandom_range(1, 12)), 9'($urandom_range(1, 12)),
				$urandom_range(32'h0000_2000, 32'h0003_0000));
			fill_and_probe();
			random_mix(50);
		end

		settle();
		repeat (4) @(posedge clk);
		$display("Run covered %0d pixel writes and %0d renders over %0d register settings",
			sb.writes, sb.renders, settings_run);
		$display("%0d output pixels checked, %0d mismatches, %0d renders unanswered",
			sb.checked, sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("uniform_bilinear_image_scaler verification clean");
		else
			$display("uniform_bilinear_image_scaler verification failed");
		$finish;
	end

endmodule

FILE: uniform_bilinear_image_scaler.f
rtl/bis_pkg.sv
rtl/bis_if.sv
rtl/bis_frame_store.sv
rtl/bis_interp.sv
rtl/bis_out_fifo.sv
rtl/uniform_bilinear_image_scaler.sv
dv/uniform_bilinear_image_scaler_tb.sv
